@@ sv/pat_pkg.sv @@
package pat_pkg;

    localparam int DEPTH_DEFAULT = 32;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 6;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;

    // operation codes carried by kind
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd5;

    typedef enum logic [1:0] {
        RA_IDX,
        RA_DEC,
        RA_INC
    } raddr_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LEN,
        IDX_POS,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        LEN_HOLD,
        LEN_CLEAR,
        LEN_INC,
        LEN_DEC
    } len_op_t;

    typedef struct packed {
        logic                load;
        idx_op_t             idx_op;
        len_op_t             len_op;
        logic                re;
        raddr_sel_t          raddr_sel;
        logic                we;
        logic                wr_put;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
        logic                emit_idx;
        logic                emit_data;
    } pat_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              full;
        logic              empty;
        logic              ins_bad;
        logic              del_bad;
        logic              ins_more;
        logic              del_more;
        logic              srch_more;
        logic              match;
        logic              rd_last;
        logic              out_free;
    } pat_stat_t;

endpackage

@@ sv/pat_ram.sv @@
module pat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held between reads
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/pat_ctrl.sv @@
module pat_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pat_pkg::pat_stat_t stat,
    output pat_pkg::pat_cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DECODE   = 12'b0000_0000_0010,
        S_INS_RD   = 12'b0000_0000_0100,
        S_INS_WR   = 12'b0000_0000_1000,
        S_INS_PUT  = 12'b0000_0001_0000,
        S_DEL_RD   = 12'b0000_0010_0000,
        S_DEL_WR   = 12'b0000_0100_0000,
        S_SRCH_RD  = 12'b0000_1000_0000,
        S_SRCH_CMP = 12'b0001_0000_0000,
        S_RD_RD    = 12'b0010_0000_0000,
        S_RD_EMIT  = 12'b0100_0000_0000,
        S_EMIT     = 12'b1000_0000_0000
    } state_t;

    state_t                        state_reg, state_next;
    logic [pat_pkg::STATUS_W-1:0]  code_reg, code_next;

    // sequence one operation at a time
    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.kind)
                    pat_pkg::KIND_CLEAR: begin
                        cmd.len_op = pat_pkg::LEN_CLEAR;
                        code_next  = pat_pkg::ST_OK;
                        state_next = S_EMIT;
                    end
                    pat_pkg::KIND_INSERT: begin
                        if (stat.full) begin
                            code_next  = pat_pkg::ST_FULL;
                            state_next = S_EMIT;
                        end else if (stat.ins_bad) begin
                            code_next  = pat_pkg::ST_BADPOS;
                            state_next = S_EMIT;
                        end else begin
                            cmd.idx_op = pat_pkg::IDX_LEN;
                            state_next = S_INS_RD;
                        end
                    end
                    pat_pkg::KIND_DELETE: begin
                        if (stat.empty) begin
                            code_next  = pat_pkg::ST_EMPTY;
                            state_next = S_EMIT;
                        end else if (stat.del_bad) begin
                            code_next  = pat_pkg::ST_BADPOS;
                            state_next = S_EMIT;
                        end else begin
                            cmd.idx_op = pat_pkg::IDX_POS;
                            state_next = S_DEL_RD;
                        end
                    end
                    pat_pkg::KIND_SEARCH: begin
                        cmd.idx_op = pat_pkg::IDX_ZERO;
                        state_next = S_SRCH_RD;
                    end
                    pat_pkg::KIND_READ: begin
                        if (stat.empty) begin
                            code_next  = pat_pkg::ST_EMPTY;
                            state_next = S_EMIT;
                        end else begin
                            cmd.idx_op = pat_pkg::IDX_ZERO;
                            state_next = S_RD_RD;
                        end
                    end
                    default: begin
                        // unused kind: drop it
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INS_RD: begin
                if (stat.ins_more) begin
                    cmd.re        = 1'b1;
                    cmd.raddr_sel = pat_pkg::RA_DEC;
                    state_next    = S_INS_WR;
                end else begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_WR: begin
                cmd.we     = 1'b1;
                cmd.idx_op = pat_pkg::IDX_DEC;
                state_next = S_INS_RD;
            end
            S_INS_PUT: begin
                cmd.we     = 1'b1;
                cmd.wr_put = 1'b1;
                cmd.len_op = pat_pkg::LEN_INC;
                code_next  = pat_pkg::ST_OK;
                state_next = S_EMIT;
            end
            S_DEL_RD: begin
                if (stat.del_more) begin
                    cmd.re        = 1'b1;
                    cmd.raddr_sel = pat_pkg::RA_INC;
                    state_next    = S_DEL_WR;
                end else begin
                    cmd.len_op = pat_pkg::LEN_DEC;
                    code_next  = pat_pkg::ST_OK;
                    state_next = S_EMIT;
                end
            end
            S_DEL_WR: begin
                cmd.we     = 1'b1;
                cmd.idx_op = pat_pkg::IDX_INC;
                state_next = S_DEL_RD;
            end
            S_SRCH_RD: begin
                if (stat.srch_more) begin
                    cmd.re        = 1'b1;
                    cmd.raddr_sel = pat_pkg::RA_IDX;
                    state_next    = S_SRCH_CMP;
                end else begin
                    code_next  = pat_pkg::ST_NOTFOUND;
                    state_next = S_EMIT;
                end
            end
            S_SRCH_CMP: begin
                if (stat.match) begin
                    if (stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = pat_pkg::ST_FOUND;
                        cmd.emit_idx    = 1'b1;
                        state_next      = S_IDLE;
                    end
                end else begin
                    cmd.idx_op = pat_pkg::IDX_INC;
                    state_next = S_SRCH_RD;
                end
            end
            S_RD_RD: begin
                cmd.re        = 1'b1;
                cmd.raddr_sel = pat_pkg::RA_IDX;
                state_next    = S_RD_EMIT;
            end
            S_RD_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = pat_pkg::ST_OK;
                    cmd.emit_idx    = 1'b1;
                    cmd.emit_data   = 1'b1;
                    if (stat.rd_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.idx_op = pat_pkg::IDX_INC;
                        state_next = S_RD_RD;
                    end
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = code_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= pat_pkg::ST_OK;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

@@ sv/pat_dp.sv @@
module pat_dp #(
    parameter int DEPTH = pat_pkg::DEPTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic        [pat_pkg::KIND_W-1:0]   s_kind,
    input  logic        [pat_pkg::POS_W-1:0]    s_position,
    input  logic signed [pat_pkg::DATA_W-1:0]   s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic        [pat_pkg::STATUS_W-1:0] m_status,
    output logic        [pat_pkg::POS_W-1:0]    m_found_position,
    output logic signed [pat_pkg::DATA_W-1:0]   m_data,
    output logic                               m_last,
    input  pat_pkg::pat_cmd_t                  cmd,
    output pat_pkg::pat_stat_t                 stat
);

    localparam int LW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = ((LW > pat_pkg::POS_W) ? LW : pat_pkg::POS_W) + 1;

    logic        [pat_pkg::KIND_W-1:0]   kind_reg;
    logic        [pat_pkg::POS_W-1:0]    pos_reg;
    logic signed [pat_pkg::DATA_W-1:0]   value_reg;
    logic        [LW-1:0]                len_reg, len_next;
    logic        [LW-1:0]                idx_reg, idx_next;
    logic        [LW-1:0]                idx_dec;
    logic        [CW-1:0]                pos_ext, len_ext, idx_ext, idx_plus, pos_m1;

    logic                                m_valid_reg, m_valid_next;
    logic        [pat_pkg::STATUS_W-1:0] m_status_reg;
    logic        [pat_pkg::POS_W-1:0]    m_pos_reg;
    logic signed [pat_pkg::DATA_W-1:0]   m_data_reg;
    logic                                m_last_reg;

    logic        [AW-1:0]                raddr, waddr;
    logic signed [pat_pkg::DATA_W-1:0]   wdata, rdata;

    // hold the accepted operation
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= s_kind;
            pos_reg   <= s_position;
            value_reg <= s_value;
        end
    end

    assign pos_ext  = CW'(pos_reg);
    assign len_ext  = CW'(len_reg);
    assign idx_ext  = CW'(idx_reg);
    assign idx_plus = idx_ext + CW'(1);
    assign pos_m1   = pos_ext - CW'(1);
    assign idx_dec  = idx_reg - LW'(1);

    // status back to the controller
    always_comb begin
        stat.kind      = kind_reg;
        stat.full      = (len_reg == LW'(DEPTH));
        stat.empty     = (len_reg == '0);
        stat.ins_bad   = (pos_reg == '0) || (pos_ext > len_ext + CW'(1));
        stat.del_bad   = (pos_reg == '0) || (pos_ext > len_ext);
        stat.ins_more  = (idx_ext >= pos_ext);
        stat.del_more  = (idx_plus < len_ext);
        stat.srch_more = (idx_ext < len_ext);
        stat.match     = (rdata == value_reg);
        stat.rd_last   = (idx_plus == len_ext);
        stat.out_free  = !m_valid_reg || m_ready;
    end

    // walk index and table length
    always_comb begin
        case (cmd.idx_op)
            pat_pkg::IDX_LEN:  idx_next = len_reg;
            pat_pkg::IDX_POS:  idx_next = LW'(pos_m1);
            pat_pkg::IDX_ZERO: idx_next = '0;
            pat_pkg::IDX_INC:  idx_next = LW'(idx_plus);
            pat_pkg::IDX_DEC:  idx_next = idx_dec;
            default:           idx_next = idx_reg;
        endcase
        case (cmd.len_op)
            pat_pkg::LEN_CLEAR: len_next = '0;
            pat_pkg::LEN_INC:   len_next = len_reg + LW'(1);
            pat_pkg::LEN_DEC:   len_next = len_reg - LW'(1);
            default:            len_next = len_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            len_reg <= '0;
        end else begin
            idx_reg <= idx_next;
            len_reg <= len_next;
        end
    end

    // table storage: shift one entry per read/write pair
    always_comb begin
        case (cmd.raddr_sel)
            pat_pkg::RA_DEC: raddr = idx_dec[AW-1:0];
            pat_pkg::RA_INC: raddr = idx_plus[AW-1:0];
            default:         raddr = idx_reg[AW-1:0];
        endcase
        waddr = cmd.wr_put ? pos_m1[AW-1:0] : idx_reg[AW-1:0];
        wdata = cmd.wr_put ? value_reg : rdata;
    end

    pat_ram #(
        .WIDTH(pat_pkg::DATA_W),
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_ram (
        .clk  (aclk),
        .we   (cmd.we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.re),
        .raddr(raddr),
        .rdata(rdata)
    );

    // output register: load on emit, drop after transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status_reg <= cmd.emit_status;
            m_pos_reg    <= cmd.emit_idx ? idx_plus[pat_pkg::POS_W-1:0] : '0;
            m_data_reg   <= cmd.emit_data ? rdata : '0;
            m_last_reg   <= cmd.emit_data ? stat.rd_last : 1'b1;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_position = m_pos_reg;
    assign m_data           = m_data_reg;
    assign m_last           = m_last_reg;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result loaded while output register busy");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(len_reg) <= CW'(DEPTH))
        else $error("table length above depth");

    a_put_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.we && cmd.wr_put) |-> (len_reg < LW'(DEPTH)))
        else $error("insert into full table");

    a_dec_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.len_op == pat_pkg::LEN_DEC) |-> (len_reg != '0))
        else $error("delete from empty table");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.we && cmd.re))
        else $error("read and write issued in one cycle");

endmodule

@@ sv/positional_array_table.sv @@
// Positional array table: an ordered list of up to DEPTH signed 32-bit words.
// Input channel (s_valid/s_ready) carries one operation per transfer: kind
// selects clear, insert, delete, search or read out; position is the 1-based
// slot for insert and delete; value is the word to insert or search for.
// Result channel (m_valid/m_ready) returns status, found_position, data and
// last; last marks the final result of an operation. Read out gives one
// result per entry, or one empty-status result on an empty table; every other
// operation gives exactly one. Unused kinds are dropped with no result.
// One operation is in flight at a time; s_ready is high only between
// operations, from the cycle after the final result is loaded. The table
// RAM has a registered read: every shifted or examined entry passes through
// a read state and then a write, compare or output state.
// Reset clears the length and the controller; the RAM needs no clearing.
// When the receiver stalls, the result waits in the output register and the
// controller pauses before loading another result until that result transfers.
module positional_array_table #(
    parameter int DEPTH = pat_pkg::DEPTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic        [pat_pkg::KIND_W-1:0]   s_kind,
    input  logic        [pat_pkg::POS_W-1:0]    s_position,
    input  logic signed [pat_pkg::DATA_W-1:0]   s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic        [pat_pkg::STATUS_W-1:0] m_status,
    output logic        [pat_pkg::POS_W-1:0]    m_found_position,
    output logic signed [pat_pkg::DATA_W-1:0]   m_data,
    output logic                               m_last
);

    pat_pkg::pat_cmd_t  cmd;
    pat_pkg::pat_stat_t stat;

    pat_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    pat_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_kind          (s_kind),
        .s_position      (s_position),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_found_position(m_found_position),
        .m_data          (m_data),
        .m_last          (m_last),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

@@ tb/sv/tb_positional_array_table.sv @@
`timescale 1ns / 100ps

module tb_positional_array_table;

    localparam int DEPTH      = 32;
    localparam int CLK_PERIOD = 10;
    localparam int N_ITEMS    = 430;
    localparam int PHASE_LEN  = 60;
    localparam int DRAIN_CYC  = 200;
    localparam int HOLD_AT    = 150;
    localparam int HOLD_CYC   = 400;
    localparam int CYCLE_MAX  = 1000000;

    localparam int KIND_W   = pat_pkg::KIND_W;
    localparam int POS_W    = pat_pkg::POS_W;
    localparam int DATA_W   = pat_pkg::DATA_W;
    localparam int STATUS_W = pat_pkg::STATUS_W;

    // one operation waiting for the driver
    typedef struct {
        logic        [KIND_W-1:0] kind;
        logic        [POS_W-1:0]  pos;
        logic signed [DATA_W-1:0] value;
        int                       phase;
    } table_op_t;

    // one result the table should return
    typedef struct {
        logic        [STATUS_W-1:0] status;
        logic        [POS_W-1:0]    fpos;
        logic signed [DATA_W-1:0]   data;
        logic                       last;
    } table_resp_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic        [KIND_W-1:0]     s_kind = '0;
    logic        [POS_W-1:0]      s_position = '0;
    logic signed [DATA_W-1:0]     s_value = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic        [STATUS_W-1:0]   m_status;
    logic        [POS_W-1:0]      m_found_position;
    logic signed [DATA_W-1:0]     m_data;
    logic                         m_last;

    table_op_t   op_q[$];
    table_resp_t resp_q[$];

    // shadow of the table contents
    logic signed [DATA_W-1:0] shadow_tbl[DEPTH];
    int                       shadow_len = 0;

    // length as the stimulus generator sees it
    int                       gen_len = 0;
    logic signed [DATA_W-1:0] value_pool[8];

    int   fail_cnt = 0;
    int   accepted_cnt = 0;
    int   cycle_cnt = 0;
    int   cur_phase = 0;
    bit   in_xfer = 1'b0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;

    positional_array_table #(
        .DEPTH(DEPTH)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_position       (s_position),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_position (m_found_position),
        .m_data           (m_data),
        .m_last           (m_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int sender_idle_pct(input int phase);
        case (phase)
            1: return 69;
            3: return 19;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(input int phase);
        case (phase)
            2: return 69;
            3: return 19;
            default: return 0;
        endcase
    endfunction

    function automatic void push_resp(input logic [STATUS_W-1:0] status,
                                      input int fpos, input logic signed [DATA_W-1:0] data,
                                      input logic last);
        table_resp_t r;
        r.status = status;
        r.fpos   = fpos[POS_W-1:0];
        r.data   = data;
        r.last   = last;
        resp_q.push_back(r);
    endfunction

    // apply one accepted operation to the shadow table and queue its results
    function automatic void apply_table_op(input logic [KIND_W-1:0] kind,
                                           input logic [POS_W-1:0] pos,
                                           input logic signed [DATA_W-1:0] word);
        int p;
        int slot;
        bit hit;
        p   = pos;
        hit = 1'b0;
        case (kind)
            pat_pkg::KIND_CLEAR: begin
                shadow_len = 0;
                push_resp(pat_pkg::ST_OK, 0, '0, 1'b1);
            end
            pat_pkg::KIND_INSERT: begin
                if (shadow_len >= DEPTH) begin
                    push_resp(pat_pkg::ST_FULL, 0, '0, 1'b1);
                end else if (p < 1 || p > shadow_len + 1) begin
                    push_resp(pat_pkg::ST_BADPOS, 0, '0, 1'b1);
                end else begin
                    for (slot = shadow_len; slot >= p; slot--)
                        shadow_tbl[slot] = shadow_tbl[slot-1];
                    shadow_tbl[p-1] = word;
                    shadow_len++;
                    push_resp(pat_pkg::ST_OK, 0, '0, 1'b1);
                end
            end
            pat_pkg::KIND_DELETE: begin
                if (shadow_len == 0) begin
                    push_resp(pat_pkg::ST_EMPTY, 0, '0, 1'b1);
                end else if (p < 1 || p > shadow_len) begin
                    push_resp(pat_pkg::ST_BADPOS, 0, '0, 1'b1);
                end else begin
                    for (slot = p - 1; slot + 1 < shadow_len; slot++)
                        shadow_tbl[slot] = shadow_tbl[slot+1];
                    shadow_len--;
                    push_resp(pat_pkg::ST_OK, 0, '0, 1'b1);
                end
            end
            pat_pkg::KIND_SEARCH: begin
                for (slot = 0; slot < shadow_len && !hit; slot++) begin
                    if (shadow_tbl[slot] == word) begin
                        push_resp(pat_pkg::ST_FOUND, slot + 1, '0, 1'b1);
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    push_resp(pat_pkg::ST_NOTFOUND, 0, '0, 1'b1);
            end
            pat_pkg::KIND_READ: begin
                if (shadow_len == 0) begin
                    push_resp(pat_pkg::ST_EMPTY, 0, '0, 1'b1);
                end else begin
                    for (slot = 0; slot < shadow_len; slot++)
                        push_resp(pat_pkg::ST_OK, slot + 1, shadow_tbl[slot],
                                  slot + 1 == shadow_len);
                end
            end
            default: ;  // unused kinds are dropped
        endcase
    endfunction

    // queue one operation and track the length it leaves behind
    function automatic void add_op(input logic [KIND_W-1:0] kind, input int pos,
                                   input logic signed [DATA_W-1:0] value);
        table_op_t op;
        op.kind  = kind;
        op.pos   = pos[POS_W-1:0];
        op.value = value;
        op.phase = (op_q.size() / PHASE_LEN) % 4;
        op_q.push_back(op);
        case (kind)
            pat_pkg::KIND_CLEAR: gen_len = 0;
            pat_pkg::KIND_INSERT:
                if (gen_len < DEPTH && op.pos >= 1 && op.pos <= gen_len + 1) gen_len++;
            pat_pkg::KIND_DELETE:
                if (gen_len > 0 && op.pos >= 1 && op.pos <= gen_len) gen_len--;
            default: ;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(99) < 60)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // position outside the valid range for the current length: zero or past the bound
    function automatic int pick_bad_pos(input int bound);
        if ($urandom_range(1) == 0 || bound >= (1 << POS_W) - 1)
            return 0;
        return $urandom_range((1 << POS_W) - 1, bound + 1);
    endfunction

    // fill the pending queue: directed cases, then random sequences
    initial begin
        int r;
        value_pool[0] = 32'sh7FFFFFFF;
        value_pool[1] = 32'sh80000000;
        value_pool[2] = '0;
        value_pool[3] = -1;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;

        // empty table: empty status wins over a bad position
        add_op(pat_pkg::KIND_READ, 0, '0);
        add_op(pat_pkg::KIND_DELETE, 1, '0);
        add_op(pat_pkg::KIND_DELETE, 0, '0);
        add_op(pat_pkg::KIND_SEARCH, 0, '0);
        add_op(pat_pkg::KIND_INSERT, 0, 5);
        add_op(pat_pkg::KIND_INSERT, 2, 5);
        // build a short table with extreme words and a duplicate
        add_op(pat_pkg::KIND_INSERT, 1, 32'sh7FFFFFFF);
        add_op(pat_pkg::KIND_INSERT, 1, 32'sh80000000);
        add_op(pat_pkg::KIND_INSERT, 3, -1);
        add_op(pat_pkg::KIND_INSERT, 2, 0);
        add_op(pat_pkg::KIND_INSERT, 1, -1);
        add_op(pat_pkg::KIND_INSERT, (1 << POS_W) - 1, 7);
        add_op(pat_pkg::KIND_SEARCH, 0, -1);
        add_op(pat_pkg::KIND_SEARCH, 0, 32'sh7FFFFFFF);
        add_op(pat_pkg::KIND_SEARCH, 0, 12345);
        add_op(pat_pkg::KIND_READ, 0, '0);
        add_op(pat_pkg::KIND_DELETE, 0, '0);
        add_op(pat_pkg::KIND_DELETE, 6, '0);
        add_op(pat_pkg::KIND_DELETE, 5, '0);
        add_op(pat_pkg::KIND_DELETE, 1, '0);
        for (int k = pat_pkg::KIND_READ + 1; k < (1 << KIND_W); k++)
            add_op(k[KIND_W-1:0], (1 << POS_W) - 1, $urandom);
        add_op(pat_pkg::KIND_READ, 0, '0);
        add_op(pat_pkg::KIND_CLEAR, 0, '0);
        add_op(pat_pkg::KIND_READ, 0, '0);

        // fill to the top: full status wins over a bad position
        while (gen_len < DEPTH)
            add_op(pat_pkg::KIND_INSERT, gen_len + 1, pick_value());
        add_op(pat_pkg::KIND_INSERT, 0, pick_value());
        add_op(pat_pkg::KIND_INSERT, DEPTH + 1, pick_value());
        add_op(pat_pkg::KIND_INSERT, 1, pick_value());
        add_op(pat_pkg::KIND_READ, 0, '0);
        add_op(pat_pkg::KIND_DELETE, DEPTH + 1, '0);
        add_op(pat_pkg::KIND_DELETE, DEPTH, '0);

        while (op_q.size() < N_ITEMS) begin
            r = $urandom_range(99);
            if (r < 3) begin
                // burst up to full, then push against the limit
                while (gen_len < DEPTH)
                    add_op(pat_pkg::KIND_INSERT, $urandom_range(gen_len + 1, 1),
                           pick_value());
                add_op(pat_pkg::KIND_INSERT, $urandom_range((1 << POS_W) - 1),
                       pick_value());
                add_op(pat_pkg::KIND_SEARCH, 0, pick_value());
            end else if (r < 12) begin
                // noise: any kind, any position
                add_op(KIND_W'($urandom_range((1 << KIND_W) - 1)),
                       $urandom_range((1 << POS_W) - 1), $urandom);
            end else if (r < 16) begin
                add_op(pat_pkg::KIND_CLEAR, $urandom_range((1 << POS_W) - 1), $urandom);
            end else if (r < 56) begin
                if ($urandom_range(9) == 0)
                    add_op(pat_pkg::KIND_INSERT, pick_bad_pos(gen_len + 1), pick_value());
                else
                    add_op(pat_pkg::KIND_INSERT, $urandom_range(gen_len + 1, 1),
                           pick_value());
            end else if (r < 78) begin
                if ($urandom_range(9) == 0 || gen_len == 0)
                    add_op(pat_pkg::KIND_DELETE, pick_bad_pos(gen_len), $urandom);
                else
                    add_op(pat_pkg::KIND_DELETE, $urandom_range(gen_len, 1), $urandom);
            end else if (r < 92) begin
                add_op(pat_pkg::KIND_SEARCH, $urandom_range((1 << POS_W) - 1),
                       pick_value());
            end else begin
                add_op(pat_pkg::KIND_READ, $urandom_range((1 << POS_W) - 1), $urandom);
            end
        end
    end

    // hold reset low, then release it between edges
    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // drive the next operation; hold the current one until it transfers
    always @(negedge aclk) begin
        table_op_t op;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_xfer) begin
            s_valid <= 1'b1;
        end else if (op_q.size() > 0 &&
                     $urandom_range(99) >= sender_idle_pct(op_q[0].phase)) begin
            op = op_q.pop_front();
            s_valid    <= 1'b1;
            s_kind     <= op.kind;
            s_position <= op.pos;
            s_value    <= op.value;
            cur_phase  <= op.phase;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // long receiver hold-off once, so the table stalls its input
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
            hold_left <= HOLD_CYC;
            hold_done <= 1'b1;
        end
    end

    // receiver ready with random stalls
    always @(negedge aclk) begin
        m_ready <= aresetn && hold_left == 0 &&
                   $urandom_range(99) >= receiver_stall_pct(cur_phase);
    end

    // check each result transfer, then predict from each input transfer
    always @(posedge aclk) begin
        table_resp_t exp_r;
        in_xfer <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (resp_q.size() == 0) begin
                    $error("unexpected result: status %0d position %0d data %0d last %0d",
                           m_status, m_found_position, m_data, m_last);
                    fail_cnt++;
                end else begin
                    exp_r = resp_q.pop_front();
                    if (m_status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, m_status);
                        fail_cnt++;
                    end
                    if (m_found_position !== exp_r.fpos) begin
                        $error("found_position: expected %0d, got %0d",
                               exp_r.fpos, m_found_position);
                        fail_cnt++;
                    end
                    if (m_data !== exp_r.data) begin
                        $error("data: expected %0d, got %0d", exp_r.data, m_data);
                        fail_cnt++;
                    end
                    if (m_last !== exp_r.last) begin
                        $error("last: expected %0d, got %0d", exp_r.last, m_last);
                        fail_cnt++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_table_op(s_kind, s_position, s_value);
                accepted_cnt <= accepted_cnt + 1;
            end
        end
    end

    // stop a hung run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_MAX) begin
            $display("tb: failure");
            $finish;
        end
    end

    // wait for all transfers and results, drain, then report
    initial begin
        @(posedge aresetn);
        while (op_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (resp_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (fail_cnt == 0 && resp_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
